@@ rtl/ipk_pkg.sv @@
// Package for the iambic paddle keyer: shared types, register indexes,
// keyer phases and fixed arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps

package ipk_pkg;

  // Field widths of the configuration registers.
  localparam int DIT_W  = 8;
  localparam int MODE_W = 2;
  localparam int PCT_W  = 7;
  localparam int LAT_W  = 4;
  localparam int CS_W   = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Element length (up to three dits) and its product with a percentage.
  localparam int LEN_W  = DIT_W + 2;
  localparam int PROD_W = LEN_W + PCT_W;

  // Division by 100 as a multiplication by a rounded-up reciprocal. Exact for
  // every dividend below 2^24 / 84, far above the largest product.
  localparam int                  RECIP_W       = 18;
  localparam logic [RECIP_W-1:0]  DIV100_MUL    = 18'd167773;
  localparam int                  DIV100_SHIFT  = 24;
  localparam int                  SCALED_W      = PROD_W + RECIP_W;
  localparam int                  QUOT_W        = SCALED_W - DIV100_SHIFT;

  // Products of a 4-bit count with the dit length.
  localparam int DITMUL_W = LAT_W + DIT_W;

  // Fixed offsets of the early paddle check.
  localparam int CURTIS_OFFSET      = 2;
  localparam int NONSQUEEZE_OFFSET  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIT_LENGTH    = 3'd0,
    REG_KEYER_MODE    = 3'd1,
    REG_DOT_CHECK     = 3'd2,
    REG_DASH_CHECK    = 3'd3,
    REG_LATENCY       = 3'd4,
    REG_CHAR_SPACE    = 3'd5,
    REG_SWAP_PADDLES  = 3'd6
  } reg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IAMBIC_A    = 2'd0,
    MODE_IAMBIC_B    = 2'd1,
    MODE_ULTIMATIC   = 2'd2,
    MODE_NON_SQUEEZE = 2'd3
  } keyer_mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DIT   = 3'd1,
    PH_DAH   = 3'd2,
    PH_START = 3'd3,
    PH_KEYED = 3'd4,
    PH_INTER = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ELEM_NONE = 2'd0,
    ELEM_DIT  = 2'd1,
    ELEM_DAH  = 2'd2
  } element_t;

  typedef struct packed {
    logic [DIT_W-1:0] dit_length;
    keyer_mode_t      keyer_mode;
    logic [PCT_W-1:0] dot_check_percent;
    logic [PCT_W-1:0] dash_check_percent;
    logic [LAT_W-1:0] latency_eighths;
    logic [CS_W-1:0]  char_space_dits;
    logic             swap_paddles;
  } cfg_t;

  typedef struct packed {
    logic dit_paddle;
    logic dah_paddle;
    logic ms_tick;
  } poll_t;

  typedef struct packed {
    logic     key_down;
    element_t element_started;
    logic     char_done;
    logic     paddle_active;
  } result_t;

endpackage

@@ rtl/iambic_paddle_keyer_unit.sv @@
// Iambic paddle keyer, top level: input register, keyer core, result register.
// A poll waits in the input register until the result register can take its result.
// Throughput: one poll per cycle, limited only by stalls from the result side.
// Reset: synchronous, active low; restores register defaults and idle keyer.
// Depends on ipk_pkg, ipk_cfg_regs, ipk_core and ipk_out_reg.
`timescale 1ns / 1ps

module iambic_paddle_keyer_unit
  import ipk_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_dit_paddle,
  input  logic                  in_dah_paddle,
  input  logic                  in_ms_tick,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_key_down,
  output logic [1:0]            out_element_started,
  output logic                  out_char_done,
  output logic                  out_paddle_active,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_valid_r, in_valid_nxt;
  poll_t   poll_r;
  logic    out_ready;
  logic    step;
  result_t core_res;
  result_t res_q;

  assign cfg_ready = 1'b1;

  ipk_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held poll moves on whenever the result register can take its result.
  assign step     = in_valid_r && out_ready;
  assign in_stall = in_valid_r && !out_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) in_valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      poll_r <= '{dit_paddle: in_dit_paddle, dah_paddle: in_dah_paddle,
                  ms_tick: in_ms_tick};
    end
  end

  ipk_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .poll  (poll_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  ipk_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (core_res),
    .ready     (out_ready),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_key_down        = res_q.key_down;
  assign out_element_started = res_q.element_started;
  assign out_char_done       = res_q.char_done;
  assign out_paddle_active   = res_q.paddle_active;

endmodule

@@ rtl/ipk_cfg_regs.sv @@
// Configuration register file of the paddle keyer.
// Depends on ipk_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module ipk_cfg_regs
  import ipk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_DIT_LENGTH:   cfg_nxt.dit_length         = wr_data[DIT_W-1:0];
        REG_KEYER_MODE:   cfg_nxt.keyer_mode         = keyer_mode_t'(wr_data[MODE_W-1:0]);
        REG_DOT_CHECK:    cfg_nxt.dot_check_percent  = wr_data[PCT_W-1:0];
        REG_DASH_CHECK:   cfg_nxt.dash_check_percent = wr_data[PCT_W-1:0];
        REG_LATENCY:      cfg_nxt.latency_eighths    = wr_data[LAT_W-1:0];
        REG_CHAR_SPACE:   cfg_nxt.char_space_dits    = wr_data[CS_W-1:0];
        REG_SWAP_PADDLES: cfg_nxt.swap_paddles       = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dit_length         <= 8'd60;
      cfg_r.keyer_mode         <= MODE_IAMBIC_B;
      cfg_r.dot_check_percent  <= 7'd35;
      cfg_r.dash_check_percent <= 7'd75;
      cfg_r.latency_eighths    <= 4'd4;
      cfg_r.char_space_dits    <= 4'd0;
      cfg_r.swap_paddles       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/ipk_core.sv @@
// Keyer state machine with its latches, millisecond clock and timers.
// Takes one registered poll per step; depends on ipk_pkg.
`timescale 1ns / 1ps

module ipk_core
  import ipk_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  poll_t   poll,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t               phase_r, phase_nxt;
  logic                 dit_latch_r, dit_latch_nxt;
  logic                 dah_latch_r, dah_latch_nxt;
  logic                 last_dit_r, last_dit_nxt;
  logic                 first_dit_r, first_dit_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] elem_end_r, elem_end_nxt;
  logic [TIME_BITS-1:0] early_r, early_nxt;
  logic [TIME_BITS-1:0] mute_end_r, mute_end_nxt;
  logic [TIME_BITS-1:0] space_end_r, space_end_nxt;
  // The Curtis check offset is kept as a raw product until the element is
  // keyed, so that the multiply and the divide by 100 sit in separate steps.
  logic                 early_scale_r, early_scale_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  logic                 pd, ph;
  logic                 is_dit;
  logic [LEN_W-1:0]     len;
  logic [PCT_W-1:0]     pct;
  logic [SCALED_W-1:0]  scaled;
  logic [QUOT_W-1:0]    quot;
  logic [TIME_BITS-1:0] early_base;
  logic [LAT_W-1:0]     lat;
  logic [DITMUL_W-1:0]  mute_len;
  logic [DITMUL_W-1:0]  space_len;
  logic                 dl, hl;
  logic                 next_dit;
  element_t             started;
  logic                 done;

  function automatic logic is_after(input logic [TIME_BITS-1:0] a,
                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  function automatic logic is_before(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  assign pd = cfg.swap_paddles ? poll.dah_paddle : poll.dit_paddle;
  assign ph = cfg.swap_paddles ? poll.dit_paddle : poll.dah_paddle;

  assign is_dit = (phase_r == PH_DIT);
  assign len    = is_dit ? LEN_W'(cfg.dit_length)
                         : LEN_W'({cfg.dit_length, 1'b0}) + LEN_W'(cfg.dit_length);
  assign pct    = is_dit ? cfg.dot_check_percent : cfg.dash_check_percent;

  assign scaled     = SCALED_W'(prod_r) * SCALED_W'(DIV100_MUL);
  assign quot       = scaled[SCALED_W-1:DIV100_SHIFT];
  assign early_base = early_scale_r ? TIME_BITS'(quot) + TIME_BITS'(CURTIS_OFFSET)
                                    : early_r;

  assign lat       = (cfg.latency_eighths == '0) ? '0 : cfg.latency_eighths - 1'b1;
  assign mute_len  = DITMUL_W'(lat) * DITMUL_W'(cfg.dit_length);
  assign space_len = DITMUL_W'(cfg.char_space_dits) * DITMUL_W'(cfg.dit_length);

  assign dl = dit_latch_r | pd;
  assign hl = dah_latch_r | ph;

  always_comb begin
    unique case (cfg.keyer_mode)
      MODE_NON_SQUEEZE: next_dit = first_dit_r;
      MODE_ULTIMATIC:   next_dit = !first_dit_r;
      default:          next_dit = !last_dit_r;
    endcase
  end

  always_comb begin
    phase_nxt       = phase_r;
    dit_latch_nxt   = dit_latch_r;
    dah_latch_nxt   = dah_latch_r;
    last_dit_nxt    = last_dit_r;
    first_dit_nxt   = first_dit_r;
    now_nxt         = now_r + TIME_BITS'(poll.ms_tick);
    elem_end_nxt    = elem_end_r;
    early_nxt       = early_r;
    mute_end_nxt    = mute_end_r;
    space_end_nxt   = space_end_r;
    early_scale_nxt = early_scale_r;
    prod_nxt        = prod_r;
    started         = ELEM_NONE;
    done            = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (pd || ph) begin
          dit_latch_nxt = dit_latch_r | pd;
          dah_latch_nxt = dah_latch_r | ph;
          first_dit_nxt = pd;
          phase_nxt     = pd ? PH_DIT : PH_DAH;
        end
      end
      PH_DIT, PH_DAH: begin
        // A pending character space holds the element back.
        if (cfg.char_space_dits == '0 || is_after(now_nxt, space_end_r)) begin
          dit_latch_nxt   = 1'b0;
          dah_latch_nxt   = 1'b0;
          last_dit_nxt    = is_dit;
          elem_end_nxt    = TIME_BITS'(len);
          early_scale_nxt = (cfg.keyer_mode == MODE_IAMBIC_B);
          prod_nxt        = PROD_W'(len) * PROD_W'(pct);
          early_nxt       = (cfg.keyer_mode == MODE_NON_SQUEEZE)
                            ? TIME_BITS'(NONSQUEEZE_OFFSET) : TIME_BITS'(len);
          phase_nxt       = PH_START;
        end
      end
      PH_START: begin
        started         = last_dit_r ? ELEM_DIT : ELEM_DAH;
        elem_end_nxt    = elem_end_r + now_nxt;
        early_nxt       = early_base + now_nxt;
        early_scale_nxt = 1'b0;
        phase_nxt       = PH_KEYED;
      end
      PH_KEYED: begin
        if (is_after(now_nxt, elem_end_r)) begin
          elem_end_nxt = now_nxt + TIME_BITS'(cfg.dit_length);
          mute_end_nxt = now_nxt + TIME_BITS'(mute_len[DITMUL_W-1:3]);
          phase_nxt    = PH_INTER;
        end else if (is_after(now_nxt, early_r)) begin
          if (last_dit_r) dah_latch_nxt = hl;
          else            dit_latch_nxt = dl;
        end
      end
      PH_INTER: begin
        if (is_before(now_nxt, mute_end_r)) begin
          if (last_dit_r) dah_latch_nxt = hl;
          else            dit_latch_nxt = dl;
        end else begin
          dit_latch_nxt = dl;
          dah_latch_nxt = hl;
          if (is_after(now_nxt, elem_end_r)) begin
            priority if (dl && hl) begin
              phase_nxt = next_dit ? PH_DIT : PH_DAH;
            end else if (dl) begin
              phase_nxt = PH_DIT;
            end else if (hl) begin
              phase_nxt = PH_DAH;
            end else begin
              phase_nxt     = PH_IDLE;
              done          = 1'b1;
              dit_latch_nxt = 1'b0;
              dah_latch_nxt = 1'b0;
              last_dit_nxt  = 1'b0;
              if (cfg.char_space_dits != '0) begin
                space_end_nxt = now_nxt + TIME_BITS'(space_len);
              end
            end
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      dit_latch_r   <= 1'b0;
      dah_latch_r   <= 1'b0;
      last_dit_r    <= 1'b0;
      first_dit_r   <= 1'b0;
      now_r         <= '0;
      elem_end_r    <= '0;
      early_r       <= '0;
      mute_end_r    <= '0;
      space_end_r   <= '0;
      early_scale_r <= 1'b0;
      prod_r        <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      dit_latch_r   <= dit_latch_nxt;
      dah_latch_r   <= dah_latch_nxt;
      last_dit_r    <= last_dit_nxt;
      first_dit_r   <= first_dit_nxt;
      now_r         <= now_nxt;
      elem_end_r    <= elem_end_nxt;
      early_r       <= early_nxt;
      mute_end_r    <= mute_end_nxt;
      space_end_r   <= space_end_nxt;
      early_scale_r <= early_scale_nxt;
      prod_r        <= prod_nxt;
    end
  end

  assign res.key_down        = (phase_nxt == PH_KEYED);
  assign res.element_started = started;
  assign res.char_done       = done;
  assign res.paddle_active   = dit_latch_nxt | dah_latch_nxt;

endmodule

@@ rtl/ipk_out_reg.sv @@
// Result register of the paddle keyer; holds a result while the sink stalls.
// Depends on ipk_pkg for the result_t bundle.
`timescale 1ns / 1ps

module ipk_out_reg
  import ipk_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    ready,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t res_out
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) valid_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

@@ bench/iambic_paddle_keyer_unit_test.sv @@
// Self-checking testbench for the iambic paddle keyer unit: paddle polls are
// checked against a cycle-free keyer predictor under random idling on both sides.
// Depends on ipk_pkg and iambic_paddle_keyer_unit.
`timescale 1ns / 1ps

module iambic_paddle_keyer_unit_test;
  import ipk_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int MAX_WAIT    = 16;
  localparam int DRAIN_TAIL  = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_dit_paddle;
  logic                  in_dah_paddle;
  logic                  in_ms_tick;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_key_down;
  logic [1:0]            out_element_started;
  logic                  out_char_done;
  logic                  out_paddle_active;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  iambic_paddle_keyer_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_dit_paddle       (in_dit_paddle),
    .in_dah_paddle       (in_dah_paddle),
    .in_ms_tick          (in_ms_tick),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_key_down        (out_key_down),
    .out_element_started (out_element_started),
    .out_char_done       (out_char_done),
    .out_paddle_active   (out_paddle_active),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Keyer predictor state and its copy of the registers.
  cfg_t        model_cfg;
  phase_t      kp_phase;
  bit          kp_dit_latch, kp_dah_latch, kp_last_dit, kp_first_dit;
  logic [31:0] kp_now, kp_elem_end, kp_check_at, kp_mute_end, kp_space_end;

  result_t pending_results[$];
  int      mismatch_count = 0;
  bit      send_idle_on = 1'b0;
  bit      recv_idle_on = 1'b0;
  int      recv_hold = 0;

  // Random paddle pattern currently held, as {dit, dah}.
  logic [1:0] held_paddles = 2'b00;
  int         held_left = 0;

  function automatic bit time_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && !d[31];
  endfunction

  function automatic bit time_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function void reset_keyer_model();
    model_cfg.dit_length         = 8'd60;
    model_cfg.keyer_mode         = MODE_IAMBIC_B;
    model_cfg.dot_check_percent  = 7'd35;
    model_cfg.dash_check_percent = 7'd75;
    model_cfg.latency_eighths    = 4'd4;
    model_cfg.char_space_dits    = 4'd0;
    model_cfg.swap_paddles       = 1'b0;
    kp_phase     = PH_IDLE;
    kp_dit_latch = 0;
    kp_dah_latch = 0;
    kp_last_dit  = 0;
    kp_first_dit = 0;
    kp_now       = 0;
    kp_elem_end  = 0;
    kp_check_at  = 0;
    kp_mute_end  = 0;
    kp_space_end = 0;
  endfunction

  function void set_latches(bit d, bit h);
    if (d) kp_dit_latch = 1;
    if (h) kp_dah_latch = 1;
  endfunction

  // Only the paddle opposite to the element just sent may latch.
  function void latch_opposite(bit d, bit h);
    if (kp_last_dit) set_latches(1'b0, h);
    else set_latches(d, 1'b0);
  endfunction

  function void start_element(bit is_dit);
    logic [31:0] len, pct;
    len = is_dit ? 32'(model_cfg.dit_length) : 32'(model_cfg.dit_length) * 3;
    pct = is_dit ? 32'(model_cfg.dot_check_percent) : 32'(model_cfg.dash_check_percent);
    // A pending character space holds the element back.
    if (model_cfg.char_space_dits != 0 && !time_after(kp_now, kp_space_end)) return;
    kp_dit_latch = 0;
    kp_dah_latch = 0;
    kp_last_dit  = is_dit;
    kp_elem_end  = len;
    case (model_cfg.keyer_mode)
      MODE_IAMBIC_B:    kp_check_at = CURTIS_OFFSET + (len * pct) / 100;
      MODE_NON_SQUEEZE: kp_check_at = NONSQUEEZE_OFFSET;
      default:          kp_check_at = len;
    endcase
    kp_phase = PH_START;
  endfunction

  function result_t keyer_poll(bit dit_in, bit dah_in, bit tick);
    bit          d, h, done, next_dit;
    element_t    started;
    logic [31:0] lat;
    result_t     r;
    d = model_cfg.swap_paddles ? dah_in : dit_in;
    h = model_cfg.swap_paddles ? dit_in : dah_in;
    started = ELEM_NONE;
    done = 0;
    if (tick) kp_now = kp_now + 1;
    case (kp_phase)
      PH_IDLE: begin
        if (d || h) begin
          set_latches(d, h);
          kp_first_dit = d;
          kp_phase = d ? PH_DIT : PH_DAH;
        end
      end
      PH_DIT: start_element(1'b1);
      PH_DAH: start_element(1'b0);
      PH_START: begin
        started = kp_last_dit ? ELEM_DIT : ELEM_DAH;
        kp_elem_end = kp_elem_end + kp_now;
        kp_check_at = kp_check_at + kp_now;
        kp_phase = PH_KEYED;
      end
      PH_KEYED: begin
        if (time_after(kp_now, kp_elem_end)) begin
          lat = (model_cfg.latency_eighths == 0) ? 0 : 32'(model_cfg.latency_eighths) - 1;
          kp_elem_end = kp_now + 32'(model_cfg.dit_length);
          kp_mute_end = kp_now + (lat * 32'(model_cfg.dit_length)) / 8;
          kp_phase = PH_INTER;
        end else if (time_after(kp_now, kp_check_at)) begin
          latch_opposite(d, h);
        end
      end
      PH_INTER: begin
        if (time_before(kp_now, kp_mute_end)) begin
          latch_opposite(d, h);
        end else begin
          set_latches(d, h);
          if (time_after(kp_now, kp_elem_end)) begin
            if (kp_dit_latch && kp_dah_latch) begin
              if (model_cfg.keyer_mode == MODE_NON_SQUEEZE) next_dit = kp_first_dit;
              else if (model_cfg.keyer_mode == MODE_ULTIMATIC) next_dit = !kp_first_dit;
              else next_dit = !kp_last_dit;
              kp_phase = next_dit ? PH_DIT : PH_DAH;
            end else if (kp_dit_latch) begin
              kp_phase = PH_DIT;
            end else if (kp_dah_latch) begin
              kp_phase = PH_DAH;
            end else begin
              kp_phase = PH_IDLE;
              done = 1;
              if (model_cfg.char_space_dits != 0)
                kp_space_end = kp_now + 32'(model_cfg.char_space_dits) *
                               32'(model_cfg.dit_length);
              kp_dit_latch = 0;
              kp_dah_latch = 0;
              kp_last_dit  = 0;
            end
          end
        end
      end
      default: kp_phase = PH_IDLE;
    endcase
    r.key_down        = (kp_phase == PH_KEYED);
    r.element_started = started;
    r.char_done       = done;
    r.paddle_active   = kp_dit_latch || kp_dah_latch;
    return r;
  endfunction

  // Result side: after each transfer, stall for a random hold-off while receive idling is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      recv_hold = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) recv_hold = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      else if (recv_hold > 0) recv_hold--;
      out_stall <= (recv_hold > 0);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no poll pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_key_down !== want.key_down) begin
          $error("key_down: expected %0d, got %0d", want.key_down, out_key_down);
          mismatch_count++;
        end
        if (out_element_started !== want.element_started) begin
          $error("element_started: expected %0d, got %0d", want.element_started,
                 out_element_started);
          mismatch_count++;
        end
        if (out_char_done !== want.char_done) begin
          $error("char_done: expected %0d, got %0d", want.char_done, out_char_done);
          mismatch_count++;
        end
        if (out_paddle_active !== want.paddle_active) begin
          $error("paddle_active: expected %0d, got %0d", want.paddle_active,
                 out_paddle_active);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_poll(bit d, bit h, bit t);
    int gap;
    gap = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_dit_paddle <= d;
    in_dah_paddle <= h;
    in_ms_tick    <= t;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(keyer_poll(d, h, t));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIT_LENGTH:   model_cfg.dit_length         = data[DIT_W-1:0];
      REG_KEYER_MODE:   model_cfg.keyer_mode         = keyer_mode_t'(data[MODE_W-1:0]);
      REG_DOT_CHECK:    model_cfg.dot_check_percent  = data[PCT_W-1:0];
      REG_DASH_CHECK:   model_cfg.dash_check_percent = data[PCT_W-1:0];
      REG_LATENCY:      model_cfg.latency_eighths    = data[LAT_W-1:0];
      REG_CHAR_SPACE:   model_cfg.char_space_dits    = data[CS_W-1:0];
      REG_SWAP_PADDLES: model_cfg.swap_paddles       = data[0];
      default: ;
    endcase
  endtask

  // Writes every register; nothing may be in flight while this runs.
  task automatic apply_config(cfg_t c);
    write_reg(REG_DIT_LENGTH, 8'(c.dit_length));
    write_reg(REG_KEYER_MODE, 8'(c.keyer_mode));
    write_reg(REG_DOT_CHECK, 8'(c.dot_check_percent));
    write_reg(REG_DASH_CHECK, 8'(c.dash_check_percent));
    write_reg(REG_LATENCY, 8'(c.latency_eighths));
    write_reg(REG_CHAR_SPACE, 8'(c.char_space_dits));
    write_reg(REG_SWAP_PADDLES, 8'(c.swap_paddles));
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_idling();
    send_idle_on = ($urandom_range(0, 2) != 0);
    recv_idle_on = ($urandom_range(0, 2) != 0);
  endtask

  // Paddle patterns are held for spans comparable to an element so that
  // whole characters and squeezes form; one poll in ten is random noise.
  task automatic keying_polls(int count, int tick_pct, int pause_at);
    int         pick;
    logic [1:0] p;
    for (int i = 0; i < count; i++) begin
      if (held_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) held_paddles = 2'b00;
        else if (pick < 5) held_paddles = 2'b10;
        else if (pick < 7) held_paddles = 2'b01;
        else held_paddles = 2'b11;
        held_left = $urandom_range(1, 4 * model_cfg.dit_length + 8);
      end
      held_left--;
      p = ($urandom_range(0, 9) == 0) ? 2'($urandom) : held_paddles;
      send_poll(p[1], p[0], $urandom_range(0, 99) < tick_pct);
      if (i == pause_at) wait_results_drained();
    end
  endtask

  // Every paddle and tick combination, then short squeezes with zero-length
  // dits, zero latency and swapped paddles.
  task automatic test_directed_edges();
    cfg_t c;
    logic [2:0] combo;
    c.dit_length         = 8'd0;
    c.keyer_mode         = MODE_IAMBIC_A;
    c.dot_check_percent  = 7'd0;
    c.dash_check_percent = 7'd0;
    c.latency_eighths    = 4'd0;
    c.char_space_dits    = 4'd0;
    c.swap_paddles       = 1'b1;
    apply_config(c);
    for (int i = 0; i < 8; i++) begin
      combo = 3'(i);
      send_poll(combo[2], combo[1], combo[0]);
    end
    for (int i = 0; i < 12; i++) send_poll(i < 4, i >= 2 && i < 6, 1'b1);
    for (int i = 0; i < 4; i++) send_poll(1'b0, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_mode_sweep();
    cfg_t c;
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 3; k++) begin
        c.keyer_mode = keyer_mode_t'(m);
        case (k)
          0: begin
            c.dit_length         = 8'd0;
            c.dot_check_percent  = 7'd0;
            c.dash_check_percent = 7'd127;
            c.latency_eighths    = 4'd0;
            c.char_space_dits    = 4'd15;
            c.swap_paddles       = 1'b0;
          end
          1: begin
            c.dit_length         = 8'($urandom_range(1, 6));
            c.dot_check_percent  = 7'd100;
            c.dash_check_percent = 7'd100;
            c.latency_eighths    = 4'd8;
            c.char_space_dits    = 4'd0;
            c.swap_paddles       = 1'b1;
          end
          default: begin
            c.dit_length         = 8'($urandom_range(1, 10));
            c.dot_check_percent  = 7'($urandom_range(0, 127));
            c.dash_check_percent = 7'($urandom_range(0, 127));
            c.latency_eighths    = 4'($urandom_range(0, 15));
            c.char_space_dits    = ($urandom_range(0, 2) == 0) ? 4'd0 :
                                   4'($urandom_range(1, 15));
            c.swap_paddles       = 1'($urandom);
          end
        endcase
        pick_idling();
        apply_config(c);
        keying_polls(100, $urandom_range(0, 1) ? 100 : $urandom_range(40, 95),
                     $urandom_range(20, 80));
        wait_results_drained();
      end
    end
  endtask

  // Longest dit the register holds, with the clock ticking on every poll.
  task automatic test_long_elements();
    cfg_t c;
    c.dit_length         = 8'd255;
    c.keyer_mode         = MODE_IAMBIC_B;
    c.dot_check_percent  = 7'd100;
    c.dash_check_percent = 7'd50;
    c.latency_eighths    = 4'd15;
    c.char_space_dits    = 4'd8;
    c.swap_paddles       = 1'b0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    apply_config(c);
    keying_polls(260, 100, -1);
    wait_results_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_dit_paddle = 1'b0;
    in_dah_paddle = 1'b0;
    in_ms_tick    = 1'b0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    reset_keyer_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_mode_sweep();
    test_long_elements();
    wait_results_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ipk_pkg.sv
rtl/ipk_cfg_regs.sv
rtl/ipk_core.sv
rtl/ipk_out_reg.sv
rtl/iambic_paddle_keyer_unit.sv
bench/iambic_paddle_keyer_unit_test.sv
